// ----- hdl/ckd_pkg.sv -----
// Package for the CKD track image reformatter: constants, parse phase codes,
// register indexes and the structs passed between the parser, queue and emitter.
// No dependencies.
`default_nettype none

package ckd_pkg;

  localparam int unsigned BYTE_W       = 8;
  localparam int unsigned CODE_W       = 2;
  localparam int unsigned CFG_W        = 16;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned LEAD_MAX     = 8;
  localparam int unsigned LEAD_CNT_W   = 4;
  localparam int unsigned RES_IDX_W    = 4;
  localparam int unsigned HDR_BYTES    = 12;
  localparam int unsigned HDR_IDX_W    = 4;
  localparam int unsigned DESC_DEPTH_DEF = 4;

  localparam logic [15:0] TRK_HDR_LEN  = 16'd48;
  localparam logic [15:0] TRK_HDR_LAST = 16'd47;
  localparam logic [15:0] REC_HDR_LEN  = 16'd12;
  localparam logic [7:0]  END_BYTE     = 8'hFF;
  localparam logic [4:0]  END_COUNT    = 5'd8;

  localparam logic [15:0] TLEN_RST     = 16'd58368;
  localparam logic [7:0]  HPC_RST      = 8'd15;
  localparam logic [15:0] FCYL_RST     = 16'd0;

  localparam logic [CFG_IDX_W-1:0] REG_TRACK_LEN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEADS     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_CYL = 2'd2;

  localparam logic [CODE_W-1:0] ERR_NONE     = 2'd0;
  localparam logic [CODE_W-1:0] ERR_RESV     = 2'd1;
  localparam logic [CODE_W-1:0] ERR_OVERRUN  = 2'd2;
  localparam logic [CODE_W-1:0] ERR_TRK_HDR  = 2'd3;

  localparam logic [2:0] PH_TRK  = 3'd0;
  localparam logic [2:0] PH_HDR  = 3'd1;
  localparam logic [2:0] PH_KEY  = 3'd2;
  localparam logic [2:0] PH_DATA = 3'd3;
  localparam logic [2:0] PH_PAD  = 3'd4;
  localparam logic [2:0] PH_SKIP = 3'd5;

  typedef struct packed {
    logic                 en;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     data;
  } cfg_wr_t;

  // One burst of results: cnt lead bytes (first in the low byte), then the
  // end marker when fin is set. A nonzero code marks a single error result.
  typedef struct packed {
    logic                         fin;
    logic [CODE_W-1:0]            code;
    logic [LEAD_CNT_W-1:0]        cnt;
    logic [LEAD_MAX*BYTE_W-1:0]   bytes;
  } desc_t;

endpackage

`default_nettype wire

// ----- hdl/ckd_parse.sv -----
// Track parser: holds the configuration and track state and turns each
// accepted source byte into at most one result burst descriptor. Uses ckd_pkg.
`default_nettype none

module ckd_parse (
  input  logic            clk,
  input  logic            rst_n,
  input  ckd_pkg::cfg_wr_t cfg,
  input  logic            step,
  input  logic [7:0]      in_byte,
  output logic            push,
  output ckd_pkg::desc_t  desc
);
  import ckd_pkg::*;

  logic [15:0] tlen_r;
  logic [7:0]  hpc_r;
  logic [15:0] pos_r, pos_nxt;
  logic [2:0]  phase_r, phase_nxt;
  logic [15:0] fbl_r, fbl_nxt;
  logic [1:0]  pad_r, pad_nxt;
  logic [15:0] exp_cyl_r, exp_cyl_nxt;
  logic [7:0]  exp_head_r, exp_head_nxt;
  logic [7:0]  hb_r [HDR_BYTES];
  logic [7:0]  hb_w [HDR_BYTES];

  logic [15:0] len, room;
  logic [16:0] npos;
  logic        wrap;
  logic        wr_en;
  logic [HDR_IDX_W-1:0] wr_idx;
  logic [7:0]  any_b, resv_b, head_inc;
  logic [16:0] kd;
  logic [15:0] dlen;
  logic        hdr_mis;

  assign len  = (tlen_r < TRK_HDR_LEN) ? TRK_HDR_LEN : tlen_r;
  assign npos = {1'b0, pos_r} + 17'd1;
  assign wrap = npos >= {1'b0, len};
  assign room = wrap ? 16'd0 : 16'(({1'b0, len}) - npos);

  always_comb begin
    wr_en  = 1'b0;
    wr_idx = '0;
    if (phase_r == PH_TRK && pos_r[15:2] == 14'd4) begin
      wr_en  = 1'b1;
      wr_idx = {2'b00, pos_r[1:0]};
    end else if (phase_r == PH_HDR && fbl_r < REC_HDR_LEN) begin
      wr_en  = 1'b1;
      wr_idx = fbl_r[HDR_IDX_W-1:0];
    end
  end

  always_comb begin
    for (int i = 0; i < HDR_BYTES; i++) begin
      hb_w[i] = (wr_en && wr_idx == HDR_IDX_W'(i)) ? in_byte : hb_r[i];
    end
  end

  always_comb begin
    any_b = '0;
    resv_b = '0;
    for (int i = 0; i < HDR_BYTES; i++) begin
      any_b = any_b | hb_w[i];
    end
    for (int i = 0; i < 4; i++) begin
      resv_b = resv_b | hb_w[i];
    end
  end

  assign dlen     = {hb_w[10], hb_w[11]};
  assign kd       = {9'd0, hb_w[9]} + {1'b0, dlen};
  assign hdr_mis  = ({hb_r[0], hb_r[1]} != exp_cyl_r) || ({hb_r[2], hb_r[3]} != {8'd0, exp_head_r});
  assign head_inc = exp_head_r + 8'd1;

  always_comb begin
    phase_nxt    = phase_r;
    fbl_nxt      = fbl_r;
    pad_nxt      = pad_r;
    pos_nxt      = npos[15:0];
    exp_cyl_nxt  = exp_cyl_r;
    exp_head_nxt = exp_head_r;
    desc         = '0;

    unique case (phase_r)
      PH_TRK: begin
        if (pos_r >= TRK_HDR_LAST) begin
          if (hdr_mis) begin
            desc.cnt  = LEAD_CNT_W'(1);
            desc.code = ERR_TRK_HDR;
            phase_nxt = PH_SKIP;
          end else begin
            desc.cnt   = LEAD_CNT_W'(5);
            desc.bytes = {24'd0, exp_head_r, 8'd0, exp_cyl_r[7:0], exp_cyl_r[15:8], 8'd0};
            phase_nxt  = PH_HDR;
            fbl_nxt    = '0;
          end
        end
      end
      PH_HDR: begin
        fbl_nxt = fbl_r + 16'd1;
        if (fbl_nxt >= REC_HDR_LEN) begin
          if (any_b == 8'd0) begin
            desc.fin  = 1'b1;
            phase_nxt = PH_SKIP;
          end else if (resv_b != 8'd0) begin
            desc.cnt  = LEAD_CNT_W'(1);
            desc.code = ERR_RESV;
            phase_nxt = PH_SKIP;
          end else if (kd > {1'b0, room}) begin
            desc.cnt  = LEAD_CNT_W'(1);
            desc.code = ERR_OVERRUN;
            phase_nxt = PH_SKIP;
          end else begin
            desc.cnt   = LEAD_CNT_W'(LEAD_MAX);
            desc.bytes = {hb_w[11], hb_w[10], hb_w[9], hb_w[8],
                          hb_w[7], hb_w[6], hb_w[5], hb_w[4]};
            phase_nxt  = PH_KEY;
            fbl_nxt    = {8'd0, hb_w[9]};
            pad_nxt    = 2'd0 - kd[1:0];
          end
        end
      end
      PH_KEY, PH_DATA: begin
        desc.cnt         = LEAD_CNT_W'(1);
        desc.bytes[7:0]  = in_byte;
        if (fbl_r != 16'd0) fbl_nxt = fbl_r - 16'd1;
      end
      PH_PAD: begin
        if (pad_r != 2'd0) pad_nxt = pad_r - 2'd1;
      end
      default: begin
      end
    endcase

    if (phase_nxt == PH_KEY && fbl_nxt == 16'd0) begin
      phase_nxt = PH_DATA;
      fbl_nxt   = dlen;
    end
    if (phase_nxt == PH_DATA && fbl_nxt == 16'd0) phase_nxt = PH_PAD;
    if (phase_nxt == PH_PAD && pad_nxt == 2'd0) begin
      phase_nxt = PH_HDR;
      fbl_nxt   = '0;
    end
    if (phase_nxt == PH_HDR && fbl_nxt == 16'd0 && room < REC_HDR_LEN) begin
      desc.fin  = 1'b1;
      phase_nxt = PH_SKIP;
    end

    if (wrap) begin
      if (phase_nxt != PH_SKIP && phase_nxt != PH_TRK) desc.fin = 1'b1;
      pos_nxt   = '0;
      phase_nxt = PH_TRK;
      fbl_nxt   = '0;
      pad_nxt   = '0;
      if (head_inc >= hpc_r || head_inc == 8'd0) begin
        exp_head_nxt = '0;
        exp_cyl_nxt  = exp_cyl_r + 16'd1;
      end else begin
        exp_head_nxt = head_inc;
      end
    end
  end

  assign push = step && (desc.cnt != '0 || desc.fin);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tlen_r     <= TLEN_RST;
      hpc_r      <= HPC_RST;
      pos_r      <= '0;
      phase_r    <= PH_TRK;
      fbl_r      <= '0;
      pad_r      <= '0;
      exp_cyl_r  <= FCYL_RST;
      exp_head_r <= '0;
    end else begin
      if (cfg.en && cfg.index == REG_TRACK_LEN) tlen_r <= cfg.data;
      if (cfg.en && cfg.index == REG_HEADS) hpc_r <= cfg.data[7:0];
      if (step) begin
        pos_r      <= pos_nxt;
        phase_r    <= phase_nxt;
        fbl_r      <= fbl_nxt;
        pad_r      <= pad_nxt;
        exp_head_r <= exp_head_nxt;
      end
      if (cfg.en && cfg.index == REG_FIRST_CYL) begin
        exp_cyl_r <= cfg.data;
      end else if (step) begin
        exp_cyl_r <= exp_cyl_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step && wr_en) hb_r[wr_idx] <= in_byte;
  end

endmodule

`default_nettype wire

// ----- hdl/ckd_fifo.sv -----
// Descriptor queue between the parser and the emitter; absorbs header and
// end-marker bursts. Uses ckd_pkg for the descriptor type.
`default_nettype none

module ckd_fifo #(
  parameter int unsigned DEPTH = ckd_pkg::DESC_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  ckd_pkg::desc_t din,
  output logic           full,
  input  logic           pop,
  output ckd_pkg::desc_t dout,
  output logic           valid
);
  import ckd_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  desc_t             mem [DEPTH];
  logic [PTR_W-1:0]  wptr_r, rptr_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              do_push, do_pop;

  assign full    = cnt_r == CNT_W'(DEPTH);
  assign valid   = cnt_r != '0;
  assign dout    = mem[rptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_ff @(posedge clk) begin
    if (do_push) mem[wptr_r] <= din;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (do_push) wptr_r <= (wptr_r == PTR_W'(DEPTH - 1)) ? '0 : wptr_r + PTR_W'(1);
      if (do_pop) rptr_r <= (rptr_r == PTR_W'(DEPTH - 1)) ? '0 : rptr_r + PTR_W'(1);
      if (do_push && !do_pop) cnt_r <= cnt_r + CNT_W'(1);
      else if (do_pop && !do_push) cnt_r <= cnt_r - CNT_W'(1);
    end
  end

endmodule

`default_nettype wire

// ----- hdl/ckd_emit.sv -----
// Emitter: walks one descriptor a result at a time into the output register,
// lead bytes first and then the end marker. Uses ckd_pkg.
`default_nettype none

module ckd_emit (
  input  logic           clk,
  input  logic           rst_n,
  input  ckd_pkg::desc_t desc,
  input  logic           desc_valid,
  output logic           pop,
  output logic           out_tvalid,
  input  logic           out_tready,
  output logic [7:0]     out_tdata,
  output logic [1:0]     out_tuser,
  output logic           out_tlast
);
  import ckd_pkg::*;

  logic [RES_IDX_W-1:0] idx_r;
  logic                 ov_r;
  logic [7:0]           byte_r, byte_nxt;
  logic [CODE_W-1:0]    code_r, code_nxt;
  logic                 last_r, last_nxt;
  logic [4:0]           total;
  logic [RES_IDX_W-1:0] last_idx;
  logic                 load;

  assign total    = {1'b0, desc.cnt} + (desc.fin ? END_COUNT : 5'd0);
  assign last_idx = RES_IDX_W'(total - 5'd1);
  assign load     = desc_valid && (!ov_r || out_tready);
  assign pop      = load && idx_r == last_idx;

  always_comb begin
    if (idx_r < desc.cnt) begin
      byte_nxt = desc.bytes[idx_r[2:0]*BYTE_W +: BYTE_W];
      code_nxt = desc.code;
      last_nxt = desc.code != ERR_NONE;
    end else begin
      byte_nxt = END_BYTE;
      code_nxt = ERR_NONE;
      last_nxt = idx_r == last_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      ov_r  <= 1'b0;
    end else begin
      if (load) begin
        ov_r  <= 1'b1;
        idx_r <= pop ? '0 : idx_r + RES_IDX_W'(1);
      end else if (out_tready) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= byte_nxt;
      code_r <= code_nxt;
      last_r <= last_nxt;
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = byte_r;
  assign out_tuser  = code_r;
  assign out_tlast  = last_r;

endmodule

`default_nettype wire

// ----- hdl/ckd_track_image_reformatter.sv -----
// CKD track image reformatter, top level: parser, descriptor queue, emitter.
// Depends on ckd_pkg, ckd_parse, ckd_fifo and ckd_emit.
//
// Usage: source track image bytes enter on the in_ stream, one byte per
// request. Each byte is parsed in the cycle it is accepted; the results it
// causes (none, one, a 5-byte track header, an 8-byte record header and/or
// the eight FF end bytes, up to 16 in all) are queued as one descriptor.
// Results leave on the out_ stream: out_tdata is the byte, out_tuser the
// error code, out_tlast marks the final end byte and every error result.
// Throughput: one input byte per cycle and, while out_tready is high, one
// result per cycle; in_tready drops only while the descriptor queue
// (DESC_DEPTH entries) is full, which a burst of header results can cause
// when the receiver is slow.
// A stalled receiver holds the output register; the queue keeps taking
// input until it fills. Reset (synchronous, rst_n low) empties the queue,
// restores register defaults and expects the first track header next.
// Configuration writes are taken at any edge with cfg_wr_en high, and are
// meant to be made while the stream is idle.
`default_nettype none

module ckd_track_image_reformatter #(
  parameter int unsigned DESC_DEPTH = ckd_pkg::DESC_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] in_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] out_byte
  output logic [1:0]  out_tuser,  // [1:0] error_code
  output logic        out_tlast
);
  import ckd_pkg::*;

  cfg_wr_t cfg;
  desc_t   desc_in, desc_out;
  logic    step, push, full, pop, desc_valid;

  assign cfg       = '{en: cfg_wr_en, index: cfg_index, data: cfg_data};
  assign in_tready = !full;
  assign step      = in_tvalid && in_tready;

  ckd_parse u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .step    (step),
    .in_byte (in_tdata),
    .push    (push),
    .desc    (desc_in)
  );

  ckd_fifo #(
    .DEPTH (DESC_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .din   (desc_in),
    .full  (full),
    .pop   (pop),
    .dout  (desc_out),
    .valid (desc_valid)
  );

  ckd_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .desc       (desc_out),
    .desc_valid (desc_valid),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire

// ----- hdl/ckd_chk.sv -----
// Port checker for the CKD track image reformatter, bound to the top level.
// Sees only the top-level ports; uses ckd_pkg for codes and the end byte.
`default_nettype none

module ckd_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic [1:0] out_tuser,
  input logic       out_tlast
);
  import ckd_pkg::*;

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled result changed");

  a_error_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != ERR_NONE |-> out_tlast && out_tdata == 8'd0)
    else $error("error result not a zero last byte");

  a_last_is_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast && out_tuser == ERR_NONE |-> out_tdata == END_BYTE)
    else $error("track end not on an end marker byte");

endmodule

bind ckd_track_image_reformatter ckd_chk u_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

`default_nettype wire
